// ----- sv/rtcs_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtcs_pkg: shared types and helpers for the R-tree subtree chooser
// Holds the channel payloads, the controller state encoding, the command and
// status bundles between controller and datapath, and small rectangle helpers.
// ---------------------------------------------------------------------------
package rtcs_pkg;

   localparam int COORD_W = 16;
   localparam int AREA_W  = 32;
   localparam int IDX_W   = 5;
   localparam int NMO_W   = 6;

   // Configuration register indexes.
   localparam logic CSR_VARIANT  = 1'b0;
   localparam logic CSR_NEAR_MIN = 1'b1;

   // Input item commands.
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic               first;
      logic [COORD_W-1:0] x_low;
      logic [COORD_W-1:0] y_low;
      logic [COORD_W-1:0] x_high;
      logic [COORD_W-1:0] y_high;
      logic               points_to_leaves;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] child_index;
      logic             empty_res;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] xl;
      logic [COORD_W-1:0] yl;
      logic [COORD_W-1:0] xh;
      logic [COORD_W-1:0] yh;
   } rect_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_A_RUN,
      ST_A_DRAIN,
      ST_B_FETCH,
      ST_B_LATCH,
      ST_B_RUN,
      ST_B_DRAIN,
      ST_B_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_we;
      logic start;
      logic issue;
      logic phase_b;
      logic k_latch;
      logic eval;
   } cmd_type;

   typedef struct packed {
      logic busy;
      logic enl_nonzero;
   } status_type;

   // Width of an extent, zero when the extent is inverted.
   function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
      span = (hi >= lo) ? (hi - lo) : '0;
   endfunction

   function automatic logic [COORD_W-1:0] cmin(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
      cmin = (a < b) ? a : b;
   endfunction

   function automatic logic [COORD_W-1:0] cmax(input logic [COORD_W-1:0] a,
                                                input logic [COORD_W-1:0] b);
      cmax = (a > b) ? a : b;
   endfunction

   // Bounding box of two rectangles.
   function automatic rect_type combine(input rect_type a, input rect_type b);
      rect_type c;
      c.xl = cmin(a.xl, b.xl);
      c.yl = cmin(a.yl, b.yl);
      c.xh = cmax(a.xh, b.xh);
      c.yh = cmax(a.yh, b.yh);
      combine = c;
   endfunction

endpackage

// ----- sv/rtcs_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtcs_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; the read data is registered.
// ---------------------------------------------------------------------------
module rtcs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/rtcs_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtcs_ctrl: sequencer for the subtree chooser
// Owns the handshakes, the configuration registers, the child count, the
// loop counters and the result register, and drives the datapath commands.
// ---------------------------------------------------------------------------
module rtcs_ctrl #(
   parameter int CAPACITY = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rtcs_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rtcs_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [rtcs_pkg::NMO_W-1:0]   csr_data,
   output rtcs_pkg::cmd_type            cmd,
   input  rtcs_pkg::status_type         status,
   output logic [$clog2(CAPACITY)-1:0]  rd_addr,
   output logic [$clog2(CAPACITY)-1:0]  wr_addr,
   output logic [$clog2(CAPACITY+1)-1:0] count,
   output logic [rtcs_pkg::NMO_W-1:0]   near_min,
   input  logic [$clog2(CAPACITY)-1:0]  best_idx
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = (AW > rtcs_pkg::IDX_W) ? AW : rtcs_pkg::IDX_W;

   rtcs_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, k_ff, count_ff;
   logic [CW-1:0]        last_pos;
   logic                 variant_ff, leaf_ff, empty_ff, rsp_valid_ff;
   logic [rtcs_pkg::NMO_W-1:0] near_min_ff;
   rtcs_pkg::rsp_type    rsp_data_ff;
   logic                 req_fire, load_fire, query_fire, rsp_load;
   logic [EW-1:0]        best_ext;

   assign last_pos   = CW'(count_ff - 1'b1);
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_data.cmd == rtcs_pkg::CMD_LOAD);
   assign query_fire = req_fire && (req_data.cmd == rtcs_pkg::CMD_QUERY);
   assign rsp_load   = (state_ff == rtcs_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign best_ext   = EW'(best_idx);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtcs_pkg::ST_IDLE: begin
            if (query_fire) begin
               state_in = (count_ff == '0) ? rtcs_pkg::ST_FINISH : rtcs_pkg::ST_A_RUN;
            end
         end
         rtcs_pkg::ST_A_RUN: begin
            if (cnt_ff == last_pos) begin
               state_in = rtcs_pkg::ST_A_DRAIN;
            end
         end
         rtcs_pkg::ST_A_DRAIN: begin
            if (!status.busy) begin
               state_in = (variant_ff && leaf_ff && status.enl_nonzero) ?
                          rtcs_pkg::ST_B_FETCH : rtcs_pkg::ST_FINISH;
            end
         end
         rtcs_pkg::ST_B_FETCH: state_in = rtcs_pkg::ST_B_LATCH;
         rtcs_pkg::ST_B_LATCH: state_in = rtcs_pkg::ST_B_RUN;
         rtcs_pkg::ST_B_RUN: begin
            if (cnt_ff == last_pos) begin
               state_in = rtcs_pkg::ST_B_DRAIN;
            end
         end
         rtcs_pkg::ST_B_DRAIN: begin
            if (!status.busy) begin
               state_in = rtcs_pkg::ST_B_EVAL;
            end
         end
         rtcs_pkg::ST_B_EVAL: begin
            state_in = (k_ff == last_pos) ? rtcs_pkg::ST_FINISH : rtcs_pkg::ST_B_FETCH;
         end
         rtcs_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = rtcs_pkg::ST_IDLE;
            end
         end
         default: state_in = rtcs_pkg::ST_IDLE;
      endcase
   end

   // Command outputs decoded from the state.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rd_addr   = cnt_ff[AW-1:0];
      unique case (state_ff)
         rtcs_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.start   = query_fire;
            cmd.load_we = load_fire && (req_data.first || (count_ff < CW'(CAPACITY)));
         end
         rtcs_pkg::ST_A_RUN:   cmd.issue = 1'b1;
         rtcs_pkg::ST_A_DRAIN: cmd.phase_b = 1'b0;
         rtcs_pkg::ST_B_FETCH: begin
            cmd.phase_b = 1'b1;
            rd_addr     = k_ff[AW-1:0];
         end
         rtcs_pkg::ST_B_LATCH: begin
            cmd.phase_b = 1'b1;
            cmd.k_latch = 1'b1;
         end
         rtcs_pkg::ST_B_RUN: begin
            cmd.phase_b = 1'b1;
            cmd.issue   = 1'b1;
         end
         rtcs_pkg::ST_B_DRAIN: cmd.phase_b = 1'b1;
         rtcs_pkg::ST_B_EVAL: begin
            cmd.phase_b = 1'b1;
            cmd.eval    = 1'b1;
         end
         rtcs_pkg::ST_FINISH: cmd.phase_b = 1'b0;
         default: cmd = '0;
      endcase
   end

   assign wr_addr   = req_data.first ? '0 : count_ff[AW-1:0];
   assign csr_ready = 1'b1;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rtcs_pkg::ST_IDLE;
         count_ff     <= '0;
         variant_ff   <= 1'b0;
         near_min_ff  <= rtcs_pkg::NMO_W'(32);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_fire) begin
            if (req_data.first) begin
               count_ff <= CW'(1);
            end else if (count_ff < CW'(CAPACITY)) begin
               count_ff <= CW'(count_ff + 1'b1);
            end
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               rtcs_pkg::CSR_VARIANT:  variant_ff  <= csr_data[0];
               rtcs_pkg::CSR_NEAR_MIN: near_min_ff <= csr_data;
               default:                variant_ff  <= variant_ff;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Loop counters, query flags and the result register.
   always_ff @(posedge clock) begin
      if (state_ff == rtcs_pkg::ST_IDLE || state_ff == rtcs_pkg::ST_B_LATCH) begin
         cnt_ff <= '0;
      end else if (cmd.issue) begin
         cnt_ff <= CW'(cnt_ff + 1'b1);
      end
      if (state_ff == rtcs_pkg::ST_A_DRAIN) begin
         k_ff <= '0;
      end else if (cmd.eval) begin
         k_ff <= CW'(k_ff + 1'b1);
      end
      if (query_fire) begin
         leaf_ff  <= req_data.points_to_leaves;
         empty_ff <= (count_ff == '0);
      end
      if (rsp_load) begin
         rsp_data_ff.empty_res   <= empty_ff;
         rsp_data_ff.child_index <= empty_ff ? '0 : best_ext[rtcs_pkg::IDX_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign count     = count_ff;
   assign near_min  = near_min_ff;

endmodule

// ----- sv/rtcs_dp.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtcs_dp: datapath of the subtree chooser
// Child rectangle and per-child cost memories, a three-stage pipeline
// (span, multiply, accumulate) shared by the enlargement and overlap passes,
// and the best-candidate registers.
// ---------------------------------------------------------------------------
module rtcs_dp #(
   parameter int CAPACITY = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rtcs_pkg::cmd_type             cmd,
   input  logic [$clog2(CAPACITY)-1:0]   rd_addr,
   input  logic [$clog2(CAPACITY)-1:0]   wr_addr,
   input  logic [$clog2(CAPACITY+1)-1:0] count,
   input  logic [rtcs_pkg::NMO_W-1:0]    near_min,
   input  rtcs_pkg::req_type             req_data,
   output rtcs_pkg::status_type          status,
   output logic [$clog2(CAPACITY)-1:0]   best_idx
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CW    = $clog2(CAPACITY + 1);
   localparam int MW    = (CW > rtcs_pkg::NMO_W) ? CW : rtcs_pkg::NMO_W;
   localparam int DIF_W = rtcs_pkg::AREA_W + $clog2(CAPACITY);
   localparam int CV_W  = 2 * rtcs_pkg::AREA_W;

   rtcs_pkg::rect_type  req_rect, r_ff, rect_rd, k_rect_ff, c_new, c_k;
   logic [CV_W-1:0]     aux_rd, aux_wdata;
   logic [rtcs_pkg::AREA_W-1:0] e_rd, a_rd, e3;
   logic [rtcs_pkg::AREA_W-1:0] k_e_ff, k_a_ff, best_e_ff, best_a_ff;
   logic [AW-1:0]       k_idx_ff, best_idx_ff, idx1_ff, idx2_ff, idx3_ff;
   logic                v1_ff, v2_ff, v3_ff, have_ff;
   logic [rtcs_pkg::COORD_W-1:0] w0_in, h0_in, w1_in, h1_in;
   logic [rtcs_pkg::COORD_W-1:0] w0_ff, h0_ff, w1_ff, h1_ff;
   logic                term_in, self_in, term2_ff, self2_ff, term3_ff, self3_ff;
   logic [rtcs_pkg::AREA_W-1:0] p0_in, p1_in, p0_ff, p1_ff;
   logic [DIF_W-1:0]    dif_ff, least_ff;
   logic [CW-1:0]       rank_ff;
   logic                a_better, eligible, b_better;

   assign req_rect = '{xl: req_data.x_low, yl: req_data.y_low,
                       xh: req_data.x_high, yh: req_data.y_high};

   // Child rectangles, written by loads.
   rtcs_ram #(.WIDTH(CV_W), .DEPTH(CAPACITY)) u_rect_ram (
      .clock (clock),
      .we    (cmd.load_we),
      .waddr (wr_addr),
      .wdata (req_rect),
      .raddr (rd_addr),
      .rdata (rect_rd)
   );

   // Per-child enlargement and original area, written by the first pass.
   assign e3        = p0_ff - p1_ff;
   assign aux_wdata = {e3, p1_ff};

   rtcs_ram #(.WIDTH(CV_W), .DEPTH(CAPACITY)) u_cost_ram (
      .clock (clock),
      .we    (v3_ff && !cmd.phase_b),
      .waddr (idx3_ff),
      .wdata (aux_wdata),
      .raddr (rd_addr),
      .rdata (aux_rd)
   );

   assign e_rd = aux_rd[CV_W-1:rtcs_pkg::AREA_W];
   assign a_rd = aux_rd[rtcs_pkg::AREA_W-1:0];

   // Stage one: extents of the boxes whose areas are needed.
   assign c_new = rtcs_pkg::combine(rect_rd, r_ff);
   assign c_k   = rtcs_pkg::combine(k_rect_ff, r_ff);

   always_comb begin
      if (cmd.phase_b) begin
         // Overlap of the grown candidate, and of the candidate itself, with child j.
         w0_in = rtcs_pkg::span(rtcs_pkg::cmax(c_k.xl, rect_rd.xl),
                                rtcs_pkg::cmin(c_k.xh, rect_rd.xh));
         h0_in = rtcs_pkg::span(rtcs_pkg::cmax(c_k.yl, rect_rd.yl),
                                rtcs_pkg::cmin(c_k.yh, rect_rd.yh));
         w1_in = rtcs_pkg::span(rtcs_pkg::cmax(k_rect_ff.xl, rect_rd.xl),
                                rtcs_pkg::cmin(k_rect_ff.xh, rect_rd.xh));
         h1_in = rtcs_pkg::span(rtcs_pkg::cmax(k_rect_ff.yl, rect_rd.yl),
                                rtcs_pkg::cmin(k_rect_ff.yh, rect_rd.yh));
      end else begin
         // Grown box and original box of child i.
         w0_in = rtcs_pkg::span(c_new.xl, c_new.xh);
         h0_in = rtcs_pkg::span(c_new.yl, c_new.yh);
         w1_in = rtcs_pkg::span(rect_rd.xl, rect_rd.xh);
         h1_in = rtcs_pkg::span(rect_rd.yl, rect_rd.yh);
      end
   end

   // Child j ranks ahead of the candidate in the stable enlargement order.
   assign term_in = (e_rd < k_e_ff) || ((e_rd == k_e_ff) && (idx1_ff < k_idx_ff));
   assign self_in = (idx1_ff == k_idx_ff);

   // Stage two: the two shared multipliers.
   assign p0_in = rtcs_pkg::AREA_W'(w0_ff) * rtcs_pkg::AREA_W'(h0_ff);
   assign p1_in = rtcs_pkg::AREA_W'(w1_ff) * rtcs_pkg::AREA_W'(h1_ff);

   // Stage three and candidate comparisons.
   assign a_better = (idx3_ff == '0) || (e3 < best_e_ff) ||
                     ((e3 == best_e_ff) && (p1_ff < best_a_ff));
   assign eligible = !(MW'(count) > MW'(near_min)) || (MW'(rank_ff) < MW'(near_min));
   assign b_better = !have_ff || (dif_ff < least_ff) ||
                     ((dif_ff == least_ff) && ((k_e_ff < best_e_ff) ||
                      ((k_e_ff == best_e_ff) && (k_a_ff < best_a_ff))));

   // Pipeline valid bits and the candidate-seen flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (cmd.start) begin
            have_ff <= 1'b0;
         end else if (cmd.eval && eligible && b_better) begin
            have_ff <= 1'b1;
         end
      end
   end

   // Pipeline payload, candidate and best registers.
   always_ff @(posedge clock) begin
      idx1_ff  <= rd_addr;
      idx2_ff  <= idx1_ff;
      idx3_ff  <= idx2_ff;
      w0_ff    <= w0_in;
      h0_ff    <= h0_in;
      w1_ff    <= w1_in;
      h1_ff    <= h1_in;
      term2_ff <= term_in;
      self2_ff <= self_in;
      p0_ff    <= p0_in;
      p1_ff    <= p1_in;
      term3_ff <= term2_ff;
      self3_ff <= self2_ff;
      if (cmd.start) begin
         r_ff <= req_rect;
      end
      if (cmd.k_latch) begin
         k_rect_ff <= rect_rd;
         k_e_ff    <= e_rd;
         k_a_ff    <= a_rd;
         k_idx_ff  <= idx1_ff;
         dif_ff    <= '0;
         rank_ff   <= '0;
      end else if (v3_ff && cmd.phase_b) begin
         rank_ff <= CW'(rank_ff + term3_ff);
         if (!self3_ff && (p0_ff != '0)) begin
            dif_ff <= DIF_W'(dif_ff + DIF_W'(p0_ff - p1_ff));
         end
      end
      if (v3_ff && !cmd.phase_b && a_better) begin
         best_idx_ff <= idx3_ff;
         best_e_ff   <= e3;
         best_a_ff   <= p1_ff;
      end else if (cmd.eval && eligible && b_better) begin
         best_idx_ff <= k_idx_ff;
         best_e_ff   <= k_e_ff;
         best_a_ff   <= k_a_ff;
         least_ff    <= dif_ff;
      end
   end

   assign status.busy        = v1_ff || v2_ff || v3_ff;
   assign status.enl_nonzero = (best_e_ff != '0);
   assign best_idx           = best_idx_ff;

endmodule

// ----- sv/rtree_choose_subtree.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtree_choose_subtree: picks the child of one R-tree node for a new rectangle
// Load transfers append child boxes to the node (first=1 restarts the set);
// a query transfer returns one result with the chosen child position.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries load and query items; a load gives no result. The block
//    accepts a new item only when the previous query is done.
//  - rsp_* returns one item per query: child_index, and empty_res when the
//    node holds no children.
//  - csr_* writes variant (index 0) and near_min_overlap (index 1) while idle.
//  - With n children a query streams each child once in least-enlargement
//    mode. When the overlap rule applies, every candidate in addition
//    streams all children once through the shared two-multiplier
//    pipeline, one child per cycle, reading the child memory through its one
//    read port.
//  - Reset empties the node and sets variant 0 and near_min_overlap 32. Child
//    memory contents are kept but unused until reloaded.
//  - A stalled receiver holds the result in the output register; the block
//    can take loads meanwhile but finishes no further query until it drains.
// ---------------------------------------------------------------------------
module rtree_choose_subtree #(
   parameter int CAPACITY = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rtcs_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rtcs_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_index,
   input  logic [rtcs_pkg::NMO_W-1:0] csr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   rtcs_pkg::cmd_type          cmd;
   rtcs_pkg::status_type       status;
   logic [AW-1:0]              rd_addr, wr_addr, best_idx;
   logic [CW-1:0]              count;
   logic [rtcs_pkg::NMO_W-1:0] near_min;

   // Sequencer.
   rtcs_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .count     (count),
      .near_min  (near_min),
      .best_idx  (best_idx)
   );

   // Cost datapath.
   rtcs_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .wr_addr  (wr_addr),
      .count    (count),
      .near_min (near_min),
      .req_data (req_data),
      .status   (status),
      .best_idx (best_idx)
   );

endmodule

// ----- sv/rtcs_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtcs_checker: port-level checks for the subtree chooser
// Watches the top-level ports only and is bound to every instance.
// ---------------------------------------------------------------------------
module rtcs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input rtcs_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rtcs_pkg::rsp_type rsp_data
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // A load transfer never produces a result.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.cmd == rtcs_pkg::CMD_LOAD) |=> !$rose(rsp_valid))
      else $error("result appeared after a load");

   // An empty node reports position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |-> (rsp_data.child_index == '0))
      else $error("empty result with nonzero index");

endmodule

bind rtree_choose_subtree rtcs_checker u_rtcs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- tb/sv/rtree_choose_subtree_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtree_choose_subtree_tb: self-checking bench for the R-tree subtree chooser
// Loads child sets and sends queries under random sender and receiver stalls.
// A scoreboard predicts each chosen child from its own copy of the node and
// compares it with every returned result. Several register settings are used.
// ---------------------------------------------------------------------------
module rtree_choose_subtree_tb;

   localparam int NODE_CAP  = 32;
   localparam int STALL_CAP = 40000;

   // Predicts the chosen child and checks results in order.
   class child_choice_board;
      rtcs_pkg::rect_type           kids[NODE_CAP];
      int unsigned                  kid_count;
      bit                           rstar_mode;
      bit [rtcs_pkg::NMO_W-1:0]     near_min;
      rtcs_pkg::rsp_type            awaited[$];
      int unsigned                  errors;

      function new();
         kid_count  = 0;
         rstar_mode = 1'b0;
         near_min   = 6'd32;
         errors     = 0;
      endfunction

      function void write_reg(logic idx, logic [rtcs_pkg::NMO_W-1:0] value);
         if (idx == rtcs_pkg::CSR_VARIANT) begin
            rstar_mode = value[0];
         end else begin
            near_min = value;
         end
      endfunction

      function longint unsigned width_of(logic [rtcs_pkg::COORD_W-1:0] lo,
                                         logic [rtcs_pkg::COORD_W-1:0] hi);
         return (hi >= lo) ? longint'(hi - lo) : 0;
      endfunction

      function longint unsigned area(rtcs_pkg::rect_type a);
         return width_of(a.xl, a.xh) * width_of(a.yl, a.yh);
      endfunction

      function rtcs_pkg::rect_type bound(rtcs_pkg::rect_type a, rtcs_pkg::rect_type b);
         rtcs_pkg::rect_type c;
         c.xl = (a.xl < b.xl) ? a.xl : b.xl;
         c.yl = (a.yl < b.yl) ? a.yl : b.yl;
         c.xh = (a.xh > b.xh) ? a.xh : b.xh;
         c.yh = (a.yh > b.yh) ? a.yh : b.yh;
         return c;
      endfunction

      function longint unsigned overlap(rtcs_pkg::rect_type a, rtcs_pkg::rect_type b);
         logic [rtcs_pkg::COORD_W-1:0] lx, ly, hx, hy;
         lx = (a.xl > b.xl) ? a.xl : b.xl;
         ly = (a.yl > b.yl) ? a.yl : b.yl;
         hx = (a.xh < b.xh) ? a.xh : b.xh;
         hy = (a.yh < b.yh) ? a.yh : b.yh;
         return width_of(lx, hx) * width_of(ly, hy);
      endfunction

      // Notes an accepted input transfer and queues the expected result.
      function void note_request(rtcs_pkg::req_type q);
         rtcs_pkg::rect_type r;
         rtcs_pkg::rsp_type  res;
         longint unsigned    enl[NODE_CAP];
         longint unsigned    least_enl, a, dif, least_dif, f;
         int unsigned        order[NODE_CAP];
         int unsigned        best, n, iters, v, j, k;
         bit                 have;
         r.xl = q.x_low;
         r.yl = q.y_low;
         r.xh = q.x_high;
         r.yh = q.y_high;
         if (q.cmd == rtcs_pkg::CMD_LOAD) begin
            if (q.first) kid_count = 0;
            if (kid_count < NODE_CAP) begin
               kids[kid_count] = r;
               kid_count++;
            end
            return;
         end
         n = kid_count;
         res.child_index = '0;
         res.empty_res   = 1'b1;
         if (n == 0) begin
            awaited.push_back(res);
            return;
         end
         // Least enlargement, smaller area on ties, earliest position wins.
         best = 0;
         least_enl = 0;
         for (int i = 0; i < n; i++) begin
            a = area(kids[i]);
            enl[i] = area(bound(kids[i], r)) - a;
            if (i == 0 || enl[i] < least_enl) begin
               least_enl = enl[i];
               best = i;
            end else if (enl[i] == least_enl && a < area(kids[best])) begin
               best = i;
            end
         end
         // Overlap rule for leaf-level nodes when enlargement is unavoidable.
         if (rstar_mode && q.points_to_leaves && least_enl != 0) begin
            have = 0;
            least_dif = 0;
            for (int i = 0; i < n; i++) order[i] = i;
            if (n > near_min) begin
               for (int i = 1; i < n; i++) begin
                  v = order[i];
                  j = i;
                  while (j > 0 && enl[order[j-1]] > enl[v]) begin
                     order[j] = order[j-1];
                     j--;
                  end
                  order[j] = v;
               end
               iters = near_min;
            end else begin
               iters = n;
            end
            for (int i = 0; i < iters; i++) begin
               k = order[i];
               dif = 0;
               for (int m = 0; m < n; m++) begin
                  if (m != k) begin
                     f = overlap(bound(kids[k], r), kids[m]);
                     if (f != 0) dif += f - overlap(kids[k], kids[m]);
                  end
               end
               if (!have || dif < least_dif) begin
                  have = 1;
                  least_dif = dif;
                  best = k;
               end else if (dif == least_dif) begin
                  if (enl[k] == enl[best]) begin
                     if (area(kids[k]) < area(kids[best])) best = k;
                  end else if (enl[k] < enl[best]) begin
                     best = k;
                  end
               end
            end
         end
         res.child_index = best[rtcs_pkg::IDX_W-1:0];
         res.empty_res   = 1'b0;
         awaited.push_back(res);
      endfunction

      // Compares a returned result with the oldest expectation.
      function void check_result(rtcs_pkg::rsp_type got);
         rtcs_pkg::rsp_type exp_res;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result, actual index %0d empty %0b",
                     $time, got.child_index, got.empty_res);
            errors++;
            return;
         end
         exp_res = awaited.pop_front();
         if (got.child_index !== exp_res.child_index) begin
            $display("%0t: child_index mismatch, expected %0d actual %0d",
                     $time, exp_res.child_index, got.child_index);
            errors++;
         end
         if (got.empty_res !== exp_res.empty_res) begin
            $display("%0t: empty_res mismatch, expected %0b actual %0b",
                     $time, exp_res.empty_res, got.empty_res);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   rtcs_pkg::req_type          req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rtcs_pkg::rsp_type          rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic                       csr_index;
   logic [rtcs_pkg::NMO_W-1:0] csr_data;

   child_choice_board board;
   int unsigned       send_idle;
   int unsigned       recv_idle;
   int unsigned       quiet_cycles;

   rtree_choose_subtree #(.CAPACITY(NODE_CAP)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver stalls change at the falling edge.
   always @(negedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle);
   end

   // Observe transfers at the rising edge; the watchdog counts quiet cycles.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && req_ready) begin
            board.note_request(req_data);
         end
         if (csr_valid && csr_ready) begin
            board.write_reg(csr_index, csr_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_data);
         end
         if ((req_valid && req_ready) || (csr_valid && csr_ready) ||
             (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_CAP) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Drives one item and holds it until the transfer happens.
   task automatic push_item(rtcs_pkg::req_type q);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic push_rect(logic cmd, logic first, int xl, int yl, int xh, int yh,
                            logic leaves);
      rtcs_pkg::req_type q;
      q.cmd = cmd;
      q.first = first;
      q.x_low = xl[15:0];
      q.y_low = yl[15:0];
      q.x_high = xh[15:0];
      q.y_high = yh[15:0];
      q.points_to_leaves = leaves;
      push_item(q);
   endtask

   // Waits for the block to drain, then writes both registers.
   task automatic set_regs(logic rstar, logic [rtcs_pkg::NMO_W-1:0] nmo);
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      for (int i = 0; i < 2; i++) begin
         csr_valid = 1'b1;
         csr_index = (i == 0) ? rtcs_pkg::CSR_VARIANT : rtcs_pkg::CSR_NEAR_MIN;
         csr_data  = (i == 0) ? {5'd0, rstar} : nmo;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
         csr_valid = 1'b0;
      end
   endtask

   // Random rectangle: mostly clustered boxes so that children overlap.
   task automatic random_item(logic cmd, logic first);
      int xl, yl, xh, yh, style;
      style = $urandom_range(9);
      if (style == 0) begin
         xl = $urandom_range(65535);
         yl = $urandom_range(65535);
         xh = $urandom_range(65535);
         yh = $urandom_range(65535);
      end else if (style == 1) begin
         xh = $urandom_range(300);
         yh = $urandom_range(300);
         xl = xh + $urandom_range(40);
         yl = yh + $urandom_range(40);
      end else begin
         xl = $urandom_range(300);
         yl = $urandom_range(300);
         xh = xl + $urandom_range(80);
         yh = yl + $urandom_range(80);
      end
      push_rect(cmd, first, xl, yl, xh, yh, $urandom_range(9) < 7);
   endtask

   initial begin
      logic                       rstar_list[6];
      logic [rtcs_pkg::NMO_W-1:0] nmo_list[6];
      int                         sent, loads;
      board = new();
      rstar_list = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
      nmo_list   = '{6'd32, 6'd32, 6'd1, 6'd0, 6'd63, 6'd3};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = rtcs_pkg::CSR_VARIANT;
      csr_data = '0;
      send_idle = 17;
      recv_idle = 77;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty node, extreme and inverted boxes, ties, overlap rule.
      push_rect(rtcs_pkg::CMD_QUERY, 0, 5, 5, 9, 9, 1);
      push_rect(rtcs_pkg::CMD_LOAD, 1, 0, 0, 65535, 65535, 0);
      push_rect(rtcs_pkg::CMD_LOAD, 0, 65535, 65535, 0, 0, 0);
      push_rect(rtcs_pkg::CMD_LOAD, 0, 10, 10, 20, 20, 0);
      push_rect(rtcs_pkg::CMD_QUERY, 0, 15, 15, 30, 30, 0);
      push_rect(rtcs_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 1);
      set_regs(1'b1, 6'd32);
      push_rect(rtcs_pkg::CMD_LOAD, 1, 0, 0, 10, 10, 0);
      push_rect(rtcs_pkg::CMD_LOAD, 0, 8, 0, 20, 10, 0);
      push_rect(rtcs_pkg::CMD_LOAD, 0, 0, 8, 10, 20, 0);
      push_rect(rtcs_pkg::CMD_LOAD, 0, 0, 8, 10, 20, 0);
      push_rect(rtcs_pkg::CMD_QUERY, 0, 9, 9, 12, 12, 1);
      push_rect(rtcs_pkg::CMD_QUERY, 0, 9, 9, 12, 12, 0);
      push_rect(rtcs_pkg::CMD_QUERY, 0, 2, 2, 3, 3, 1);
      push_rect(rtcs_pkg::CMD_QUERY, 0, 30, 30, 31, 31, 1);
      set_regs(1'b1, 6'd0);
      push_rect(rtcs_pkg::CMD_QUERY, 0, 9, 9, 12, 12, 1);

      // Random: each phase uses one register setting and one stall pattern.
      for (int ph = 0; ph < 6; ph++) begin
         send_idle = (ph < 2) ? 17 : (ph < 4) ? 77 : 0;
         recv_idle = (ph < 2) ? 77 : (ph < 4) ? 17 : 0;
         set_regs(rstar_list[ph], nmo_list[ph]);
         sent = 0;
         while (sent < 205) begin
            if ($urandom_range(9) == 0) begin
               loads = $urandom_range(30, 34);
            end else begin
               loads = $urandom_range(0, 8);
            end
            for (int i = 0; i < loads; i++) random_item(rtcs_pkg::CMD_LOAD, i == 0);
            for (int i = $urandom_range(1, 3); i > 0; i--) begin
               random_item(rtcs_pkg::CMD_QUERY, 0);
            end
            sent += loads + 2;
         end
      end

      while (board.awaited.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
